>>> rtl/assert_macros.svh
// Assertion macros used by the key state tracker core RTL.
// Clocked, reset-qualified implication checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KKST_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kkst_pkg.sv
// Package for the key state tracker: sizes, key codes, command and register
// codes, shared structs and search functions. No dependencies.
package kkst_pkg;

    localparam int KEY_COUNT  = 768;
    localparam int KEY_W      = 10;
    localparam int CNT_W      = $clog2(KEY_COUNT + 1);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = (KEY_COUNT + WORD_W - 1) / WORD_W;
    localparam int IDX_W      = $clog2(NUM_WORDS);
    localparam int DELAY_W    = 16;
    localparam int MOD_W      = 6;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam logic [KEY_W-1:0] KC_LSHIFT = KEY_W'(42);
    localparam logic [KEY_W-1:0] KC_RSHIFT = KEY_W'(54);
    localparam logic [KEY_W-1:0] KC_LCTRL  = KEY_W'(29);
    localparam logic [KEY_W-1:0] KC_RCTRL  = KEY_W'(97);
    localparam logic [KEY_W-1:0] KC_LALT   = KEY_W'(56);
    localparam logic [KEY_W-1:0] KC_RALT   = KEY_W'(100);
    localparam logic [KEY_W-1:0] KC_CAPS   = KEY_W'(58);
    localparam logic [KEY_W-1:0] KC_NUM    = KEY_W'(69);

    typedef enum logic [CMD_W-1:0] {
        CMD_KEY     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONSOLE_GRAPHIC = 1'd0,
        REG_KEY_DELAY       = 1'd1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } map_rd_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } map_wr_t;

    typedef struct packed {
        logic               released_one;
        logic               keys_remain;
        logic [MOD_W-1:0]   modifiers;
        logic               key_is_pressed;
        logic [DELAY_W-1:0] fwd_delay;
        logic               sent_down;
        logic [KEY_W-1:0]   sent_code;
        logic               forwarded;
    } result_t;

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_word(input logic [NUM_WORDS-1:0] nz);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (nz[i]) begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> rtl/keyboard_key_state_tracker_core.sv
// Keyboard key state tracker, top level: FSM, modifier flags, config
// registers and result register. Depends on kkst_pkg, kkst_map, assert_macros.svh.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command in s_tuser and
//   key_code/key_down in s_tdata. Every item gives exactly one result item
//   on m_tvalid/m_tready (m_tdata fields listed at the port).
//   Configuration (console_graphic, key_delay) is written on cfg_valid/
//   cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//   An item is taken in the idle state while the bitmap word it needs is read,
//   and is modified and written back in the modify step, which also loads
//   the result into the output register; a new item is accepted only after
//   the previous one has left the modify step. The release command finds the
//   lowest pressed word from a per-word summary, so it takes the same steps.
//   The result register holds while m_tready is low; a following item may
//   still be accepted and waits in the modify step until the register frees.
//   Reset clears the pressed map (through the summary), the modifiers and
//   both configuration registers; no clearing pass is needed.
`include "assert_macros.svh"

module keyboard_key_state_tracker_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [9:0] key_code, [10] key_down, rest zero
    input  logic [kkst_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] command
    input  logic [kkst_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] forwarded, [10:1] sent_code, [11] sent_down, [27:12] fwd_delay,
    // [28] key_is_pressed, [34:29] modifiers, [35] keys_remain,
    // [36] released_one, rest zero
    output logic [kkst_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kkst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kkst_pkg::DELAY_W-1:0]        cfg_data
);
    import kkst_pkg::*;

    localparam int RES_W = $bits(result_t);

    state_t              st_reg, st_next;
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    code_reg;
    logic                down_reg;
    logic [IDX_W-1:0]    idx_reg, idx_sel;
    logic                found_reg;
    logic [5:0]          mk_reg, mk_next;     // lsh, rsh, lctrl, rctrl, lalt, ralt
    logic                caps_reg, caps_next, num_reg, num_next;
    logic                graphic_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic                m_tvalid_reg;
    result_t             res_reg, res_next;

    logic                s_accept, mod_fire;
    cmd_t                s_cmd;
    logic [KEY_W-1:0]    s_code;
    logic                s_in_range, in_range;
    map_rd_t             map_rd;
    map_wr_t             map_wr;
    logic [WORD_W-1:0]   word, new_word;
    logic [NUM_WORDS-1:0] nz;
    logic [BIT_W-1:0]    low_bit, eff_bit;
    logic [KEY_W-1:0]    eff_code;
    logic                eff_down, apply, cur;
    logic [MOD_W-1:0]    mods;

    assign s_cmd      = cmd_t'(s_tuser);
    assign s_code     = s_tdata[KEY_W-1:0];
    assign s_in_range = (CNT_W'(s_code) < CNT_W'(KEY_COUNT));
    assign in_range   = (CNT_W'(code_reg) < CNT_W'(KEY_COUNT));
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:   if (s_accept) st_next = ST_MODIFY;
            ST_MODIFY: if (mod_fire) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        mod_fire = 1'b0;
        case (st_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_MODIFY: mod_fire = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                mod_fire = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (s_cmd == CMD_RELEASE) begin
            idx_sel = lowest_word(nz);
        end else if (s_in_range) begin
            idx_sel = IDX_W'(s_code[KEY_W-1:BIT_W]);
        end else begin
            idx_sel = '0;
        end
    end

    assign map_rd.en  = s_accept;
    assign map_rd.idx = idx_sel;

    kkst_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (map_rd),
        .wr      (map_wr),
        .rd_word (word),
        .nz      (nz)
    );

    // modify step
    always_comb begin
        low_bit  = lowest_bit(word);
        cur      = word[code_reg[BIT_W-1:0]];
        eff_code = code_reg;
        eff_bit  = code_reg[BIT_W-1:0];
        eff_down = 1'b0;
        apply    = 1'b0;
        case (cmd_reg)
            CMD_KEY: begin
                eff_down = down_reg;
                apply    = in_range && (down_reg || cur);
            end
            CMD_RELEASE: begin
                eff_bit  = low_bit;
                eff_code = (KEY_W'(idx_reg) << BIT_W) | KEY_W'(low_bit);
                apply    = found_reg;
            end
            default: apply = 1'b0;
        endcase

        new_word          = word;
        new_word[eff_bit] = eff_down;

        mk_next   = mk_reg;
        caps_next = caps_reg;
        num_next  = num_reg;
        if (apply) begin
            case (eff_code)
                KC_LSHIFT: mk_next[0] = eff_down;
                KC_RSHIFT: mk_next[1] = eff_down;
                KC_LCTRL:  mk_next[2] = eff_down;
                KC_RCTRL:  mk_next[3] = eff_down;
                KC_LALT:   mk_next[4] = eff_down;
                KC_RALT:   mk_next[5] = eff_down;
                KC_CAPS:   caps_next  = caps_reg ^ eff_down;
                KC_NUM:    num_next   = num_reg ^ eff_down;
                default:   mk_next    = mk_reg;
            endcase
        end
        mods = {caps_next, num_next, mk_next[5], mk_next[4],
                mk_next[2] | mk_next[3], mk_next[0] | mk_next[1]};

        res_next           = '0;
        res_next.modifiers = mods;
        res_next.forwarded = apply && graphic_reg;
        res_next.sent_down = apply && graphic_reg && eff_down;
        res_next.fwd_delay = (apply && graphic_reg) ? delay_reg : '0;
        case (cmd_reg)
            CMD_KEY: begin
                res_next.sent_code = (apply && graphic_reg) ? eff_code : '0;
            end
            CMD_RELEASE: begin
                res_next.sent_code    = found_reg ? eff_code : '0;
                res_next.released_one = found_reg;
                res_next.keys_remain  = found_reg && ((new_word != '0) ||
                    ((nz & ~(NUM_WORDS'(1) << idx_reg)) != '0));
            end
            CMD_QUERY: res_next.key_is_pressed = in_range && cur;
            default:   res_next.sent_code = '0;
        endcase
    end

    assign map_wr.en   = mod_fire && apply;
    assign map_wr.idx  = idx_reg;
    assign map_wr.data = new_word;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_cmd;
            code_reg  <= s_code;
            down_reg  <= s_tdata[KEY_W];
            idx_reg   <= idx_sel;
            found_reg <= (nz != '0);
        end
        if (mod_fire) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            mk_reg       <= '0;
            caps_reg     <= 1'b0;
            num_reg      <= 1'b0;
            graphic_reg  <= 1'b0;
            delay_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (mod_fire) begin
                mk_reg       <= mk_next;
                caps_reg     <= caps_next;
                num_reg      <= num_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_CONSOLE_GRAPHIC: graphic_reg <= cfg_data[0];
                    REG_KEY_DELAY:       delay_reg   <= cfg_data;
                    default:             graphic_reg <= graphic_reg;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), res_reg};

    `KKST_ASSERT_NEXT(a_accept_to_modify, aclk, aresetn, s_accept, st_reg == ST_MODIFY, "accepted item did not enter modify step")
    `KKST_ASSERT_IMPL(a_valid_from_modify, aclk, aresetn, $rose(m_tvalid), $past(st_reg == ST_MODIFY), "result appeared without a modify step")
    `KKST_ASSERT_IMPL(a_remain_needs_release, aclk, aresetn, m_tvalid && res_reg.keys_remain, res_reg.released_one && !res_reg.sent_down, "keys_remain without a released key")
    `KKST_ASSERT_IMPL(a_write_only_on_fire, aclk, aresetn, map_wr.en, st_reg == ST_MODIFY && !(m_tvalid_reg && !m_tready), "bitmap written outside a completing modify step")

endmodule

>>> rtl/kkst_map.sv
// Pressed-key bitmap store: word memory with registered read plus a
// per-word nonzero summary. Depends on kkst_pkg.
module kkst_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kkst_pkg::map_rd_t                 rd,
    input  kkst_pkg::map_wr_t                 wr,
    output logic [kkst_pkg::WORD_W-1:0]       rd_word,
    output logic [kkst_pkg::NUM_WORDS-1:0]    nz
);
    import kkst_pkg::*;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [WORD_W-1:0]    rdata_reg;
    logic                 rd_nz_reg;
    logic [NUM_WORDS-1:0] nz_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
        if (rd.en) begin
            rdata_reg <= mem[rd.idx];
        end
    end

    // never-written words are marked zero by the summary
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg    <= '0;
            rd_nz_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                nz_reg[wr.idx] <= (wr.data != '0);
            end
            if (rd.en) begin
                rd_nz_reg <= nz_reg[rd.idx];
            end
        end
    end

    assign rd_word = rd_nz_reg ? rdata_reg : '0;
    assign nz      = nz_reg;

endmodule
